>>> src/swr_pkg.sv
// shared constants for the sampling-without-replacement remap block
`default_nettype none

package swr_pkg;

  // fixed field widths
  localparam int POS_W   = 10;
  localparam int STEP_W  = 11;
  localparam int TDATA_W = 16;

  // run tag kept beside each remap entry; tag zero marks a cleared entry
  localparam int EPOCH_W = 6;

  // population register after reset
  localparam logic [STEP_W-1:0] POP_RESET = 11'd1024;

endpackage : swr_pkg

`default_nettype wire

>>> src/sample_without_replacement_remap_core.sv
// sparse partial fisher-yates sampler: remap memories, draw sequencer and result register
//
//  channel   ports                      contents
//  -------   -------------------------  ------------------------------------------
//  in_       in_tvalid/tready/tdata     tdata[9:0] drawn_position, rest zero
//            in_tlast                   last_draw
//  out_      out_tvalid/tready/tdata    tdata[9:0] sampled_index,
//                                       tdata[10] range_error, rest zero
//  cfg_      cfg_wr_en/cfg_wr_data      population_size (11 bits)
//
// For each request the drawn position and the current step are looked up in the
// same cycle in two copies of the remap memory, and the write-back at the drawn
// position happens when the registered read data returns.
// Remap marks are run tags stored with each entry; after reset, and after every
// 63rd completed run, a clearing pass writes tag zero to every entry, and no
// request is taken during it (configuration writes still are).
// A request is taken while a result still waits on out_; the write-back then stalls
// until the result register frees.
`default_nettype none

module sample_without_replacement_remap_core
  import swr_pkg::*;
#(
  parameter int POPULATION_MAX = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // draw requests
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // [9:0] drawn_position
  input  wire logic               in_tlast,   // last_draw
  // results
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [TDATA_W-1:0] out_tdata,  // [9:0] sampled_index, [10] range_error
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic [STEP_W-1:0]  cfg_wr_data
);

  localparam int AW = (POPULATION_MAX > 1) ? $clog2(POPULATION_MAX) : 1;
  localparam int NW = $clog2(POPULATION_MAX + 1);
  localparam int CW = (NW > STEP_W) ? NW : STEP_W;
  localparam int MW = EPOCH_W + POS_W;

  localparam logic [CW-1:0]      SIZE_MAX    = CW'(POPULATION_MAX);
  localparam logic [AW-1:0]      LAST_ADDR   = AW'(POPULATION_MAX - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WRITE
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  pop_r;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               last_r, last_nxt;
  logic               err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]   out_index_r, out_index_nxt;
  logic               out_err_r, out_err_nxt;

  logic [POS_W-1:0]   in_pos;
  logic [CW-1:0]      pos_c, step_c, pop_c, size_c;
  logic               in_err;
  logic               accept;
  logic               out_free;

  logic [MW-1:0]      rdata_pos, rdata_step;
  logic               hit_pos, hit_step;
  logic [POS_W-1:0]   result, carried;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [MW-1:0]      wr_data;

  // range check against the current step and the clamped population
  assign in_pos = in_tdata[POS_W-1:0];
  assign pos_c  = CW'(in_pos);
  assign step_c = CW'(step_r);
  assign pop_c  = CW'(pop_r);
  assign size_c = (pop_c > SIZE_MAX) ? SIZE_MAX : pop_c;
  assign in_err = (pos_c < step_c) || (pos_c >= size_c);

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // entry lookup: a tag equal to the live run tag marks a remapped entry
  assign hit_pos  = (rdata_pos[MW-1 -: EPOCH_W] == epoch_r);
  assign hit_step = (rdata_step[MW-1 -: EPOCH_W] == epoch_r);
  assign result   = hit_pos ? rdata_pos[POS_W-1:0] : pos_r;
  assign carried  = hit_step ? rdata_step[POS_W-1:0] : POS_W'(step_r);

  // shared write port: clearing pass or write-back of the carried value
  always_comb begin
    if (state_r == ST_SWEEP) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
      wr_data = '0;
    end else begin
      wr_en   = (state_r == ST_WRITE) && out_free && !err_r;
      wr_addr = AW'(pos_r);
      wr_data = {epoch_r, carried};
    end
  end

  // copy looked up at the drawn position
  swr_ram #(
    .WIDTH (MW),
    .DEPTH (POPULATION_MAX)
  ) u_ram_pos (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (AW'(in_pos)),
    .rdata (rdata_pos)
  );

  // copy looked up at the current step
  swr_ram #(
    .WIDTH (MW),
    .DEPTH (POPULATION_MAX)
  ) u_ram_step (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (AW'(step_r)),
    .rdata (rdata_step)
  );

  // draw sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    epoch_nxt     = epoch_r;
    sweep_nxt     = sweep_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_index_nxt = out_index_r;
    out_err_nxt   = out_err_r;

    unique case (state_r)
      ST_SWEEP: begin
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
          epoch_nxt = EPOCH_FIRST;
          step_nxt  = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          pos_nxt   = in_pos;
          last_nxt  = in_tlast;
          err_nxt   = in_err;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = err_r ? '0 : result;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
          if (!err_r) begin
            if (last_r) begin
              // end of run: restart the step and retire the run tag
              step_nxt = '0;
              if (epoch_r == EPOCH_LAST) begin
                state_nxt = ST_SWEEP;
                sweep_nxt = '0;
              end else begin
                epoch_nxt = epoch_r + EPOCH_W'(1);
              end
            end else begin
              step_nxt = step_r + STEP_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
        sweep_nxt = '0;
      end
    endcase
  end

  // state, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      step_r      <= '0;
      epoch_r     <= EPOCH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      step_r      <= step_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    last_r      <= last_nxt;
    err_r       <= err_nxt;
    out_index_r <= out_index_nxt;
    out_err_r   <= out_err_nxt;
  end

  // population register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r <= POP_RESET;
    end else if (cfg_wr_en) begin
      pop_r <= cfg_wr_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - POS_W - 1){1'b0}}, out_err_r, out_index_r};

endmodule : sample_without_replacement_remap_core

`default_nettype wire

>>> src/swr_ram.sv
// generic simple dual-port ram with one write port and one registered read port
`default_nettype none

module swr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : swr_ram

`default_nettype wire

>>> sim/tb_sample_without_replacement_remap_core.sv
// self-checking bench for the remap sampler: directed draws, random runs, stalls and back-pressure
`default_nettype none

module tb_sample_without_replacement_remap_core;
  import swr_pkg::*;

  localparam int POP_MAX    = 1024;
  localparam int RAND_ITEMS = 1900;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic [POS_W-1:0] index;
    logic             range_err;
  } sample_t;

  // shadow of the sampler state plus the queue of samples still to come out
  class sample_tracker;
    logic [POS_W-1:0]  remap_val  [POP_MAX];
    bit                remap_mark [POP_MAX];
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] population;
    sample_t           expected_samples [$];
    int                errors;

    function new();
      foreach (remap_mark[i]) remap_mark[i] = 1'b0;
      step       = '0;
      population = POP_RESET;
      errors     = 0;
    endfunction

    function void set_population(logic [STEP_W-1:0] value);
      population = value;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // work out the sample for one accepted draw request
    function void note_draw(logic [POS_W-1:0] pos, logic last);
      sample_t          r;
      int unsigned      n;
      int unsigned      s;
      int unsigned      d;
      logic [POS_W-1:0] carried;
      n = (population > POP_MAX) ? POP_MAX : population;
      s = step;
      d = pos;
      if (d < s || d >= n) begin
        // out of range: flag only, nothing moves, last is ignored
        r.index     = '0;
        r.range_err = 1'b1;
      end else begin
        r.index     = remap_mark[d] ? remap_val[d] : pos;
        r.range_err = 1'b0;
        carried     = remap_mark[s] ? remap_val[s] : s[POS_W-1:0];
        remap_val[d]  = carried;
        remap_mark[d] = 1'b1;
        step = step + 1'b1;
        if (last) begin
          step = '0;
          foreach (remap_mark[i]) remap_mark[i] = 1'b0;
        end
      end
      expected_samples = {expected_samples, r};
    endfunction

    // compare one accepted result with the oldest sample waiting
    task check_sample(logic [TDATA_W-1:0] data);
      sample_t r;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("result 0x%0h with no request waiting", data));
        return;
      end
      r = expected_samples.pop_front();
      if (data[POS_W-1:0] !== r.index)
        report_mismatch($sformatf("sampled_index got %0d want %0d",
                                  data[POS_W-1:0], r.index));
      if (data[POS_W] !== r.range_err)
        report_mismatch($sformatf("range_error got %0b want %0b",
                                  data[POS_W], r.range_err));
    endtask
  endclass

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata    = '0;
  logic               in_tlast    = 1'b0;
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               cfg_wr_en   = 1'b0;
  logic [STEP_W-1:0]  cfg_wr_data = '0;

  sample_tracker tracker = new();

  // stimulus-side view of the run, kept apart from the tracker
  int unsigned run_step   = 0;
  int unsigned cur_pop    = POP_RESET;
  int unsigned items_sent = 0;
  int unsigned gap_max    = 15;
  int unsigned stall_max  = 15;
  bit          hold_off_req = 1'b0;

  sample_without_replacement_remap_core #(
    .POPULATION_MAX (POP_MAX)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [9:0] drawn_position
    .in_tlast    (in_tlast),    // last_draw
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [9:0] sampled_index, [10] range_error
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tracker.note_draw(in_tdata[POS_W-1:0], in_tlast);
    if (rst_n && out_tvalid && out_tready) tracker.check_sample(out_tdata);
  end

  // result side: random stalls, and one long hold-off when asked
  initial begin
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_LEN;
      end else begin
        stall = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // offer one draw request and follow the step it leaves behind
  task automatic offer_draw(input int unsigned pos, input bit last);
    int unsigned gap;
    int unsigned n_eff;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(pos);
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    n_eff = (cur_pop > POP_MAX) ? POP_MAX : cur_pop;
    if (pos >= run_step && pos < n_eff) begin
      run_step = last ? 0 : run_step + 1;
    end
  endtask

  // drop the request line and let every outstanding sample drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.expected_samples.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_population(input int unsigned value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= STEP_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_population(STEP_W'(value));
    cur_pop = value;
  endtask

  // one run: mostly in-range draws, with some broken or random ones mixed in
  task automatic play_run(input int unsigned len, input bit close);
    int unsigned n_eff;
    int unsigned pos;
    int unsigned kind;
    bit          last;
    n_eff = (cur_pop > POP_MAX) ? POP_MAX : cur_pop;
    for (int unsigned k = 0; k < len; k++) begin
      kind = $urandom_range(0, 9);
      if (run_step >= n_eff || kind == 0) begin
        kind = $urandom_range(0, 2);
        last = 1'($urandom_range(0, 1));
        if (kind == 0 && run_step > 0)
          pos = $urandom_range(0, run_step - 1);
        else if (kind == 1 && n_eff < POP_MAX)
          pos = $urandom_range(n_eff, POP_MAX - 1);
        else
          pos = $urandom_range(0, POP_MAX - 1);
      end else begin
        pos  = $urandom_range(run_step, n_eff - 1);
        last = close && (k == len - 1);
      end
      offer_draw(pos, last);
    end
  endtask

  // main sequence
  initial begin
    int unsigned pick;
    int unsigned pop;
    int unsigned n_eff;
    int unsigned cap;
    int unsigned len;
    int unsigned runs;
    bit          pressure_done;
    pressure_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full population: top position, below-step, remapped reread, draw at the step itself
    write_population(POP_MAX);
    offer_draw(1023, 0);
    offer_draw(0, 0);
    offer_draw(1023, 0);
    offer_draw(1, 0);
    offer_draw(2, 0);
    offer_draw(1023, 1);
    // last on an out-of-range draw is ignored
    offer_draw(0, 0);
    offer_draw(0, 1);
    offer_draw(1, 1);

    // population of one runs dry, last cannot end it
    wait_idle();
    write_population(1);
    offer_draw(0, 0);
    offer_draw(0, 0);
    offer_draw(0, 1);
    // growing the population mid-run frees it again
    wait_idle();
    write_population(2);
    offer_draw(1, 1);

    // empty population rejects everything
    wait_idle();
    write_population(0);
    offer_draw(0, 0);
    offer_draw(1023, 1);

    // oversize register acts as the maximum
    wait_idle();
    write_population(2047);
    offer_draw(1023, 0);
    offer_draw(0, 0);
    offer_draw(1023, 1);

    // shrink the population mid-run
    wait_idle();
    write_population(8);
    offer_draw(7, 0);
    offer_draw(6, 0);
    wait_idle();
    write_population(4);
    offer_draw(5, 0);
    offer_draw(3, 1);

    // random phases, each with its own population and idling pattern
    while (items_sent < RAND_ITEMS) begin
      wait_idle();
      pick = $urandom_range(0, 19);
      if (pick < 12)      pop = $urandom_range(1, 16);
      else if (pick < 15) pop = $urandom_range(17, POP_MAX - 1);
      else if (pick < 17) pop = POP_MAX;
      else if (pick < 19) pop = $urandom_range(POP_MAX + 1, 2047);
      else                pop = 0;
      write_population(pop);
      gap_max   = ($urandom_range(0, 4) == 0) ? 0 : 15;
      stall_max = ($urandom_range(0, 4) == 0) ? 0 : 15;
      n_eff = (pop > POP_MAX) ? POP_MAX : pop;

      if (!pressure_done && items_sent > 600) begin
        // back-pressure: results held off while requests keep coming
        pressure_done = 1'b1;
        gap_max = 0;
        hold_off_req = 1'b1;
        play_run(24, 1'b1);
        continue;
      end

      runs = $urandom_range(1, 4);
      for (int unsigned r = 0; r < runs; r++) begin
        cap = (n_eff < 48) ? n_eff : 48;
        if (cap == 0) cap = 4;
        len = $urandom_range(1, cap);
        // now and then draw a small population dry
        if (n_eff > 0 && n_eff <= 64 && $urandom_range(0, 3) == 0) len = n_eff;
        play_run(len, $urandom_range(0, 5) != 0);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : tb_sample_without_replacement_remap_core

`default_nettype wire

>>> sim.f
src/swr_pkg.sv
src/swr_ram.sv
src/sample_without_replacement_remap_core.sv
sim/tb_sample_without_replacement_remap_core.sv
